// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define APSP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define APSP_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define APSP_ASSERT(label, clk, rstn, prop, msg)
`define APSP_ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

// ===== rtl/apsp_pkg.sv =====
// Types and constants of the all-pairs shortest path block.
package apsp_pkg;

    localparam int VERTICES_DEF = 16;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 4;
    localparam int WEIGHT_W  = 16;
    localparam int DIST_W    = 24;
    localparam int EDGE_W    = WEIGHT_W + 1;
    localparam int PATH_W    = DIST_W + 1;

    localparam int S_TDATA_W = 2 * IDX_W + WEIGHT_W;
    localparam int S_TUSER_W = OP_W + 1;
    localparam int M_TDATA_W = DIST_W;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE2,
        ST_COPY,
        ST_FETCH,
        ST_RELAX,
        ST_READ
    } state_t;

    typedef struct packed {
        logic                inf;
        logic [WEIGHT_W-1:0] weight;
    } edge_t;

    typedef struct packed {
        logic              inf;
        logic [DIST_W-1:0] length;
    } path_t;

endpackage

// ===== rtl/apsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module apsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/all_pairs_shortest_path_top.sv =====
// Top level: edge store, distance store and the Floyd-Warshall sequencer.
// Write request: (row,col) stored on acceptance, (col,row) in ST_EDGE2 before the next request.
// Read request: result registered from ST_READ once the output is free, held until taken.
// Run request: ST_COPY loads the edge store into the distance store, then per intermediate
//   vertex one ST_FETCH per row plus one pair a cycle in ST_RELAX on the distance store.
// Reset: a clearing pass marks every edge store entry absent, s_tready low.
`include "assert_macros.svh"

module all_pairs_shortest_path_top #(
    parameter int VERTICES = apsp_pkg::VERTICES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [apsp_pkg::S_TDATA_W-1:0] s_tdata,  // row_index, col_index, weight
    input  logic [apsp_pkg::S_TUSER_W-1:0] s_tuser,  // operation, no_edge
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [apsp_pkg::M_TDATA_W-1:0] m_tdata,  // distance
    output logic                           m_tuser   // unreachable
);

    import apsp_pkg::*;

    localparam int VIDX_W = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int ADDR_W = 2 * VIDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CMP_W  = (VIDX_W + 1 > IDX_W) ? VIDX_W + 1 : IDX_W;
    localparam logic [VIDX_W-1:0] V_LAST  = VIDX_W'(VERTICES - 1);
    localparam logic [CMP_W-1:0]  V_LIMIT = CMP_W'(VERTICES);

    // request fields
    logic [IDX_W-1:0]    in_row;
    logic [IDX_W-1:0]    in_col;
    logic [WEIGHT_W-1:0] in_weight;
    op_t                 in_op;
    logic                in_no_edge;
    logic                in_inside;
    logic [VIDX_W-1:0]   in_rv;
    logic [VIDX_W-1:0]   in_cv;

    assign in_row     = s_tdata[IDX_W-1:0];
    assign in_col     = s_tdata[2*IDX_W-1:IDX_W];
    assign in_weight  = s_tdata[2*IDX_W+WEIGHT_W-1:2*IDX_W];
    assign in_op      = op_t'(s_tuser[OP_W-1:0]);
    assign in_no_edge = s_tuser[OP_W];
    assign in_inside  = (CMP_W'(in_row) < V_LIMIT) && (CMP_W'(in_col) < V_LIMIT);
    assign in_rv      = VIDX_W'(in_row);
    assign in_cv      = VIDX_W'(in_col);

    // registers
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [VIDX_W-1:0]   i_reg, i_next;
    logic [VIDX_W-1:0]   j_reg, j_next;
    logic [VIDX_W-1:0]   k_reg, k_next;
    logic                cp_valid_reg, cp_valid_next;
    logic [ADDR_W-1:0]   cp_addr_reg, cp_addr_next;
    logic                rx_valid_reg, rx_valid_next;
    logic [ADDR_W-1:0]   rx_addr_reg, rx_addr_next;
    logic                fetch_pend_reg, fetch_pend_next;
    path_t               dik_reg, dik_next;
    logic [VIDX_W-1:0]   row_reg, row_next;
    logic [VIDX_W-1:0]   col_reg, col_next;
    logic                inside_reg, inside_next;
    edge_t               edge_val_reg, edge_val_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [DIST_W-1:0]   m_dist_reg, m_dist_next;
    logic                m_unr_reg, m_unr_next;

    // memory ports
    logic                ew_en;
    logic [ADDR_W-1:0]   ew_addr;
    edge_t               ew_data;
    logic [ADDR_W-1:0]   er_addr;
    edge_t               er_data;
    logic                pw_en;
    logic [ADDR_W-1:0]   pw_addr;
    path_t               pw_data;
    logic [ADDR_W-1:0]   pa_addr;
    path_t               pa_data;
    logic [ADDR_W-1:0]   pb_addr;
    path_t               pb_data;

    apsp_ram #(.WIDTH(EDGE_W), .DEPTH(DEPTH)) u_edge_ram (
        .aclk    (aclk),
        .wr_en   (ew_en),
        .wr_addr (ew_addr),
        .wr_data (ew_data),
        .rd_addr (er_addr),
        .rd_data (er_data)
    );

    // distance store kept as two identical copies for two reads a cycle
    apsp_ram #(.WIDTH(PATH_W), .DEPTH(DEPTH)) u_path_ram_a (
        .aclk    (aclk),
        .wr_en   (pw_en),
        .wr_addr (pw_addr),
        .wr_data (pw_data),
        .rd_addr (pa_addr),
        .rd_data (pa_data)
    );

    apsp_ram #(.WIDTH(PATH_W), .DEPTH(DEPTH)) u_path_ram_b (
        .aclk    (aclk),
        .wr_en   (pw_en),
        .wr_addr (pw_addr),
        .wr_data (pw_data),
        .rd_addr (pb_addr),
        .rd_data (pb_data)
    );

    // copy write-back: diagonal forced to zero
    logic  cp_diag;
    path_t cp_data;

    assign cp_diag        = cp_addr_reg[ADDR_W-1:VIDX_W] == cp_addr_reg[VIDX_W-1:0];
    assign cp_data.inf    = !cp_diag && er_data.inf;
    assign cp_data.length = (cp_diag || er_data.inf) ? '0 : DIST_W'(er_data.weight);

    // relaxation: d(i,j) against d(i,k) + d(k,j)
    logic [DIST_W:0] via_sum;
    path_t           via;
    logic            improve;

    assign via_sum    = {1'b0, dik_reg.length} + {1'b0, pb_data.length};
    assign via.inf    = dik_reg.inf || pb_data.inf;
    assign via.length = via_sum[DIST_W] ? DIST_MAX : via_sum[DIST_W-1:0];
    assign improve    = !via.inf && (pa_data.inf || (via.length < pa_data.length));

    assign pw_en   = cp_valid_reg || (rx_valid_reg && improve);
    assign pw_addr = cp_valid_reg ? cp_addr_reg : rx_addr_reg;
    assign pw_data = cp_valid_reg ? cp_data : via;

    assign dik_next = fetch_pend_reg ? pb_data : dik_reg;

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        cp_valid_next   = 1'b0;
        cp_addr_next    = cp_addr_reg;
        rx_valid_next   = 1'b0;
        rx_addr_next    = rx_addr_reg;
        fetch_pend_next = 1'b0;
        row_next        = row_reg;
        col_next        = col_reg;
        inside_next     = inside_reg;
        edge_val_next   = edge_val_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_dist_next     = m_dist_reg;
        m_unr_next      = m_unr_reg;
        s_tready        = 1'b0;
        ew_en           = 1'b0;
        ew_addr         = {in_rv, in_cv};
        ew_data         = '{inf: in_no_edge, weight: in_no_edge ? '0 : in_weight};
        er_addr         = {i_reg, j_reg};
        pa_addr         = {i_reg, j_reg};
        pb_addr         = {in_rv, in_cv};

        unique case (state_reg)
            ST_CLEAR: begin
                ew_en    = 1'b1;
                ew_addr  = clr_reg;
                ew_data  = '{inf: 1'b1, weight: '0};
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = !rx_valid_reg;
                if (s_tvalid && s_tready) begin
                    row_next      = in_rv;
                    col_next      = in_cv;
                    inside_next   = in_inside;
                    edge_val_next = ew_data;
                    unique case (in_op)
                        OP_WRITE: begin
                            ew_en = in_inside;
                            if (in_inside) begin
                                state_next = ST_EDGE2;
                            end
                        end
                        OP_RUN: begin
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            state_next = ST_COPY;
                        end
                        OP_READ: begin
                            state_next = ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EDGE2: begin
                ew_en      = 1'b1;
                ew_addr    = {col_reg, row_reg};
                ew_data    = edge_val_reg;
                state_next = ST_IDLE;
            end
            ST_COPY: begin
                cp_valid_next = 1'b1;
                cp_addr_next  = {i_reg, j_reg};
                if (j_reg == V_LAST) begin
                    j_next = '0;
                    if (i_reg == V_LAST) begin
                        i_next     = '0;
                        state_next = ST_FETCH;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_FETCH: begin
                pb_addr         = {i_reg, k_reg};
                fetch_pend_next = 1'b1;
                state_next      = ST_RELAX;
            end
            ST_RELAX: begin
                pb_addr       = {k_reg, j_reg};
                rx_valid_next = 1'b1;
                rx_addr_next  = {i_reg, j_reg};
                if (j_reg == V_LAST) begin
                    j_next     = '0;
                    state_next = ST_FETCH;
                    if (i_reg == V_LAST) begin
                        i_next = '0;
                        if (k_reg == V_LAST) begin
                            k_next     = '0;
                            state_next = ST_IDLE;
                        end else begin
                            k_next = k_reg + 1'b1;
                        end
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_READ: begin
                pb_addr = {row_reg, col_reg};
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_unr_next    = !inside_reg || pb_data.inf;
                    m_dist_next   = (!inside_reg || pb_data.inf) ? DIST_MAX : pb_data.length;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            cp_valid_reg   <= 1'b0;
            rx_valid_reg   <= 1'b0;
            fetch_pend_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            cp_valid_reg   <= cp_valid_next;
            rx_valid_reg   <= rx_valid_next;
            fetch_pend_reg <= fetch_pend_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_addr_reg  <= cp_addr_next;
        rx_addr_reg  <= rx_addr_next;
        dik_reg      <= dik_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        inside_reg   <= inside_next;
        edge_val_reg <= edge_val_next;
        m_dist_reg   <= m_dist_next;
        m_unr_reg    <= m_unr_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_dist_reg;
    assign m_tuser  = m_unr_reg;

    `APSP_ASSERT_NEVER(a_single_writer, aclk, aresetn, cp_valid_reg && rx_valid_reg, "write clash")
    `APSP_ASSERT(a_fetch_then_relax, aclk, aresetn, state_reg == ST_FETCH |=> state_reg == ST_RELAX, "no relax")
    `APSP_ASSERT(a_unreach_max, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata == DIST_MAX, "bad distance")
    `APSP_ASSERT(a_result_from_read, aclk, aresetn, $rose(m_tvalid) |-> $past(state_reg == ST_READ), "stray result")

endmodule
